@@ rtl/core/apr_pkg.sv @@
package apr_pkg;

  localparam int FRAMES_DEF   = 16;
  localparam int AGE_BITS_DEF = 16;

  localparam int PAGE_W = 31;
  localparam int CNT_W  = 5;
  localparam int FIDX_W = 4;

  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

endpackage

@@ rtl/core/apr_cell.sv @@
module apr_cell
  import apr_pkg::*;
#(
  parameter int  IDX      = 0,
  parameter int  IDX_W    = 4,
  parameter int  AGE_BITS = AGE_BITS_DEF,
  parameter type carry_t  = logic,
  parameter type ctrl_t   = logic
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctrl_t  ctrl_i,
  input  carry_t carry_i,
  output carry_t carry_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic                valid_q, valid_d;
  logic [AGE_BITS-1:0] age_q, age_d;
  logic [PAGE_W-1:0]   page_q;
  carry_t              in_c, carry_d, carry_q;
  logic                is_top, active, is_sel;

  assign is_top = (MY_IDX == ctrl_i.top_idx);
  assign active = (MY_IDX <= ctrl_i.top_idx);
  assign is_sel = (MY_IDX == ctrl_i.sel);

  // the topmost active frame starts the sweep; everything runs downward
  always_comb begin
    if (is_top) begin
      in_c     = '0;
      in_c.tok = ctrl_i.inject;
    end else begin
      in_c = carry_i;
    end
  end

  always_comb begin
    carry_d = in_c;
    if (in_c.tok) begin
      if (!in_c.hit && valid_q && (page_q == ctrl_i.page)) begin
        carry_d.hit     = 1'b1;
        carry_d.hit_idx = MY_IDX;
      end
      if (!in_c.empty && !valid_q) begin
        carry_d.empty     = 1'b1;
        carry_d.empty_idx = MY_IDX;
      end
      // strict less-than keeps ties on the higher index seen first
      if (!in_c.best_set || (age_q < in_c.best_age)) begin
        carry_d.best_set  = 1'b1;
        carry_d.best_age  = age_q;
        carry_d.best_idx  = MY_IDX;
        carry_d.best_page = page_q;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    if (ctrl_i.update && active) begin
      if (is_sel) begin
        if (ctrl_i.load) begin
          valid_d = 1'b1;
          age_d   = {1'b1, {(AGE_BITS-1){1'b0}}};
        end else begin
          age_d = {1'b1, age_q[AGE_BITS-1:1]};
        end
      end else begin
        age_d = {1'b0, age_q[AGE_BITS-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
      carry_q <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update && active && is_sel && ctrl_i.load) begin
      page_q <= ctrl_i.page;
    end
  end

  assign carry_o = carry_q;

endmodule

@@ rtl/core/aging_page_replacement_core.sv @@
// Flow: an accepted reference is registered, then the search token walks the n managed frames
// (n is frames_in_use clamped to 1..FRAMES) from the top cell down, one cell per cycle;
// when it leaves the bottom cell the ages are updated, the result is registered and busy
// drops. A new reference is accepted only while busy is low.
// Reset: all frames empty, all ages zero, frames_in_use back to 16; no clearing pass.
// Results are shown for one cycle on valid_o; the receiver cannot stall them.
module aging_page_replacement_core
  import apr_pkg::*;
#(
  parameter int FRAMES   = FRAMES_DEF,
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  input  logic              start,
  output logic              busy,
  input  logic [PAGE_W-1:0] page_id_i,
  output logic              valid_o,
  output logic              hit_o,
  output logic [FIDX_W-1:0] frame_index_o,
  output logic              evicted_valid_o,
  output logic [PAGE_W-1:0] evicted_page_o
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  typedef struct packed {
    logic                tok;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic                empty;
    logic [IDX_W-1:0]    empty_idx;
    logic                best_set;
    logic [AGE_BITS-1:0] best_age;
    logic [IDX_W-1:0]    best_idx;
    logic [PAGE_W-1:0]   best_page;
  } carry_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [IDX_W-1:0]  top_idx;
    logic [IDX_W-1:0]  sel;
    logic              inject;
    logic              update;
    logic              load;
  } ctrl_t;

  typedef enum logic {IDLE, SCAN} state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cfg_q;
  logic [PAGE_W-1:0] page_q;
  logic              inject_q;
  logic              valid_q, hit_q, ev_valid_q;
  logic [FIDX_W-1:0] fidx_q;
  logic [PAGE_W-1:0] ev_page_q;

  logic [IDX_W-1:0]  top_idx;
  logic              accept, done;
  logic [IDX_W-1:0]  sel;
  logic              evict;
  ctrl_t             ctrl;
  carry_t            carry_w [FRAMES+1];
  logic [FRAMES-1:0] tok_vec;

  assign accept = start && (state_q == IDLE);
  assign busy   = (state_q != IDLE);

  always_comb begin
    if (cfg_q == '0) begin
      top_idx = '0;
    end else if (int'(cfg_q) > FRAMES) begin
      top_idx = IDX_W'(FRAMES - 1);
    end else begin
      top_idx = IDX_W'(cfg_q - CNT_W'(1));
    end
  end

  // token leaving the bottom cell ends the sweep
  assign done = (state_q == SCAN) && carry_w[0].tok;

  always_comb begin
    evict = 1'b0;
    priority if (carry_w[0].hit) begin
      sel = carry_w[0].hit_idx;
    end else if (carry_w[0].empty) begin
      sel = carry_w[0].empty_idx;
    end else begin
      sel   = carry_w[0].best_idx;
      evict = 1'b1;
    end
  end

  always_comb begin
    ctrl.page    = page_q;
    ctrl.top_idx = top_idx;
    ctrl.sel     = sel;
    ctrl.inject  = inject_q;
    ctrl.update  = done;
    ctrl.load    = !carry_w[0].hit;
  end

  assign carry_w[FRAMES] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    apr_cell #(
      .IDX      (g),
      .IDX_W    (IDX_W),
      .AGE_BITS (AGE_BITS),
      .carry_t  (carry_t),
      .ctrl_t   (ctrl_t)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .carry_i (carry_w[g+1]),
      .carry_o (carry_w[g])
    );
    assign tok_vec[g] = carry_w[g].tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= IDLE;
      cfg_q    <= CNT_RESET;
      inject_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      inject_q <= accept;
      valid_q  <= done;
      unique case (state_q)
        IDLE: begin
          if (accept) begin
            state_q <= SCAN;
          end
        end
        SCAN: begin
          if (done) begin
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= page_id_i;
    end
    if (done) begin
      hit_q      <= carry_w[0].hit;
      fidx_q     <= FIDX_W'(sel);
      ev_valid_q <= evict;
      ev_page_q  <= evict ? carry_w[0].best_page : '0;
    end
  end

  assign valid_o         = valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = fidx_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one search token in the frame chain");

  a_token_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_vec != '0) |-> (state_q == SCAN))
    else $error("search token alive while idle");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hit_o) |-> !evicted_valid_o)
    else $error("hit reported together with an eviction");

  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !evicted_valid_o) |-> (evicted_page_o == '0))
    else $error("evicted page nonzero without an eviction");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && !valid_o))
    else $error("accepted reference did not start a sweep");

endmodule
